// ===== sv/stepper_wave_drive_speed_buttons_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper wave drive assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_WAVE_DRIVE_SPEED_BUTTONS_UNIT_MACROS_SVH
`define STEPPER_WAVE_DRIVE_SPEED_BUTTONS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWDSB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swdsb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWDSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swdsb assertion failed");

`endif

// ===== sv/swdsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper wave drive package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package swdsb_pkg;

  localparam int unsigned RegW   = 8;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CoilW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [RegW-1:0] DebounceLimitRst = 8'd8;
  localparam logic [RegW-1:0] MinDelayRst      = 8'd2;
  localparam logic [RegW-1:0] MaxDelayRst      = 8'd10;
  localparam logic [RegW-1:0] InitDelayRst     = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_LIMIT = 2'd0,
    REG_MIN_DELAY      = 2'd1,
    REG_MAX_DELAY      = 2'd2,
    REG_INIT_DELAY     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RegW-1:0] debounce_limit;
    logic [RegW-1:0] min_step_delay;
    logic [RegW-1:0] max_step_delay;
  } cfg_t;

  typedef struct packed {
    logic [CoilW-1:0]  coil_drive;
    logic [RegW-1:0]   current_step_delay;
    logic [PhaseW-1:0] current_phase;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/swdsb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Stepper wave drive configuration registers
// Holds the debounce limit and the speed bounds written over the cfg port.
// ----------------------------------------------------------------------------
`default_nettype none

module swdsb_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [swdsb_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [swdsb_pkg::RegW-1:0]    cfg_data,
  output swdsb_pkg::cfg_t                    cfg
);

  swdsb_pkg::cfg_t cfg_r;
  swdsb_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Writes to the initial delay index are ignored; the core loads InitDelayRst at reset.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (swdsb_pkg::reg_idx_t'(cfg_index))
        swdsb_pkg::REG_DEBOUNCE_LIMIT: cfg_nxt.debounce_limit = cfg_data;
        swdsb_pkg::REG_MIN_DELAY:      cfg_nxt.min_step_delay = cfg_data;
        swdsb_pkg::REG_MAX_DELAY:      cfg_nxt.max_step_delay = cfg_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= swdsb_pkg::DebounceLimitRst;
      cfg_r.min_step_delay <= swdsb_pkg::MinDelayRst;
      cfg_r.max_step_delay <= swdsb_pkg::MaxDelayRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/swdsb_core.sv =====
// ----------------------------------------------------------------------------
// Stepper wave drive sequencing core
// Debounce counters, speed adjustment and phase timing for one tick a cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_wave_drive_speed_buttons_unit_macros.svh"

module swdsb_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            slower_released,
  input  wire logic            faster_released,
  input  wire swdsb_pkg::cfg_t cfg,
  output swdsb_pkg::result_t   result
);

  logic [swdsb_pkg::RegW-1:0]   slow_cnt_r, slow_cnt_nxt;
  logic [swdsb_pkg::RegW-1:0]   fast_cnt_r, fast_cnt_nxt;
  logic [swdsb_pkg::RegW-1:0]   delay_r, delay_nxt;
  logic                         slow_flag_r, slow_flag_nxt;
  logic                         fast_flag_r, fast_flag_nxt;
  logic [swdsb_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [swdsb_pkg::RegW-1:0]   tick_r, tick_nxt;
  logic                         cycle_start;
  logic                         slow_hit, fast_hit;
  logic                         slow_flag_mid, fast_flag_mid;
  logic [swdsb_pkg::RegW-1:0]   delay_mid;
  logic [swdsb_pkg::RegW-1:0]   limit;
  logic [swdsb_pkg::RegW-1:0]   limit_r;
  logic [swdsb_pkg::RegW-1:0]   tick_inc;

  assign cycle_start = (phase_r == '0) && (tick_r == '0);

  always_comb begin
    slow_cnt_nxt  = slow_cnt_r;
    fast_cnt_nxt  = fast_cnt_r;
    slow_flag_mid = slow_flag_r;
    fast_flag_mid = fast_flag_r;
    slow_hit      = 1'b0;
    fast_hit      = 1'b0;
    if (cycle_start) begin
      if (slower_released && !slow_flag_r) begin
        if (slow_cnt_r < cfg.debounce_limit) begin
          slow_cnt_nxt = slow_cnt_r + 8'd1;
        end
      end else begin
        if (slow_cnt_r == cfg.debounce_limit) begin
          slow_hit      = 1'b1;
          slow_flag_mid = 1'b0;
        end
        slow_cnt_nxt = '0;
      end
      if (faster_released && !fast_flag_r) begin
        if (fast_cnt_r < cfg.debounce_limit) begin
          fast_cnt_nxt = fast_cnt_r + 8'd1;
        end
      end else begin
        if (fast_cnt_r == cfg.debounce_limit) begin
          fast_hit      = 1'b1;
          fast_flag_mid = 1'b0;
        end
        fast_cnt_nxt = '0;
      end
    end
    slow_flag_nxt = slow_flag_mid | ~slower_released;
    fast_flag_nxt = fast_flag_mid | ~faster_released;
  end

  always_comb begin
    delay_mid = delay_r;
    if (slow_hit && (delay_r < cfg.max_step_delay)) begin
      delay_mid = delay_r + 8'd1;
    end
    delay_nxt = delay_mid;
    if (fast_hit && (delay_mid > cfg.min_step_delay)) begin
      delay_nxt = delay_mid - 8'd1;
    end
  end

  always_comb begin
    limit    = (delay_nxt == '0) ? 8'd1 : delay_nxt;
    tick_inc = tick_r + 8'd1;
    tick_nxt = tick_inc;
    phase_nxt = phase_r;
    if (tick_inc >= limit) begin
      tick_nxt  = '0;
      phase_nxt = phase_r + 2'd1;
    end
  end

  assign result.coil_drive         = swdsb_pkg::CoilW'(1) << phase_r;
  assign result.current_step_delay = delay_nxt;
  assign result.current_phase      = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_cnt_r  <= '0;
      fast_cnt_r  <= '0;
      delay_r     <= swdsb_pkg::InitDelayRst;
      slow_flag_r <= 1'b0;
      fast_flag_r <= 1'b0;
      phase_r     <= '0;
      tick_r      <= '0;
    end else if (step) begin
      slow_cnt_r  <= slow_cnt_nxt;
      fast_cnt_r  <= fast_cnt_nxt;
      delay_r     <= delay_nxt;
      slow_flag_r <= slow_flag_nxt;
      fast_flag_r <= fast_flag_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
    end
  end

  assign limit_r = (delay_r == '0) ? 8'd1 : delay_r;

  `SWDSB_ASSERT_IMPL(a_tick_below_limit, 1'b1, tick_r < limit_r)
  `SWDSB_ASSERT_NEXT(a_delay_moves_at_start, step && !cycle_start, $stable(delay_r))
  `SWDSB_ASSERT_NEXT(a_phase_moves_on_wrap, step && (tick_nxt != '0), $stable(phase_r))

endmodule

`default_nettype wire

// ===== sv/stepper_wave_drive_speed_buttons_unit.sv =====
// ----------------------------------------------------------------------------
// Stepper wave drive sequencer with speed buttons
// Each input word is one 1 ms tick carrying both button levels and yields one
// result word with the coil enables, the active step delay and the phase. A
// new word is taken every clock unless the full output stalls; the result is
// registered in the output register when the core advances. The rate is set
// by the core state update between the input and output registers.
// Configuration is taken at any time and is meant to be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_wave_drive_speed_buttons_unit_macros.svh"

module stepper_wave_drive_speed_buttons_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_slower_released,
  input  wire logic                          in_faster_released,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [swdsb_pkg::CoilW-1:0]        out_coil_drive,
  output logic [swdsb_pkg::RegW-1:0]         out_current_step_delay,
  output logic [swdsb_pkg::PhaseW-1:0]       out_current_phase,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [swdsb_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [swdsb_pkg::RegW-1:0]    cfg_data
);

  swdsb_pkg::cfg_t    cfg;
  swdsb_pkg::result_t core_res;
  swdsb_pkg::result_t res_r;
  logic               in_v_r;
  logic               slow_r;
  logic               fast_r;
  logic               out_v_r;
  logic               advance;

  swdsb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swdsb_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .slower_released (slow_r),
    .faster_released (fast_r),
    .cfg             (cfg),
    .result          (core_res)
  );

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      slow_r <= in_slower_released;
      fast_r <= in_faster_released;
    end
    if (advance) begin
      res_r <= core_res;
    end
  end

  assign out_valid              = out_v_r;
  assign out_coil_drive         = res_r.coil_drive;
  assign out_current_step_delay = res_r.current_step_delay;
  assign out_current_phase      = res_r.current_phase;

  `SWDSB_ASSERT_IMPL(a_coil_matches_phase, out_v_r, out_coil_drive == (4'd1 << out_current_phase))
  `SWDSB_ASSERT_NEXT(a_out_held, out_v_r && !out_ready, out_v_r && $stable(res_r))
  `SWDSB_ASSERT_IMPL(a_full_stalls_input, in_v_r && out_v_r && !out_ready, !in_ready)

endmodule

`default_nettype wire
